// ===== sv/sbt_pkg.sv =====
// Shared types, constants and helper functions for the source byte tokenizer.
// Used by sbt_lexer, sbt_result_queue and source_byte_tokenizer_unit; depends on nothing.

package sbt_pkg;

    localparam int LEN_BITS  = 16;
    localparam int LINE_BITS = 32;

    typedef logic [LEN_BITS-1:0]  len_t;
    typedef logic [LINE_BITS-1:0] line_t;
    typedef logic [3:0]           mode_t;

    localparam logic [62:0] INT_MAX = {63{1'b1}};

    // Scanner modes.
    localparam mode_t MODE_IDLE    = 4'd0;
    localparam mode_t MODE_IDENT   = 4'd1;
    localparam mode_t MODE_NUM     = 4'd2;
    localparam mode_t MODE_SLASH   = 4'd3;
    localparam mode_t MODE_COMMENT = 4'd4;
    localparam mode_t MODE_EQ1     = 4'd5;
    localparam mode_t MODE_EQ2     = 4'd6;
    localparam mode_t MODE_BANG1   = 4'd7;
    localparam mode_t MODE_BANG2   = 4'd8;
    localparam mode_t MODE_LT      = 4'd9;
    localparam mode_t MODE_GT      = 4'd10;

    // Token kinds.
    localparam logic [5:0] KIND_IDENT  = 6'd0;
    localparam logic [5:0] KIND_INT    = 6'd1;
    localparam logic [5:0] KIND_KW0    = 6'd2;
    localparam logic [5:0] KIND_PLUS   = 6'd12;
    localparam logic [5:0] KIND_MINUS  = 6'd13;
    localparam logic [5:0] KIND_STAR   = 6'd14;
    localparam logic [5:0] KIND_SLASH  = 6'd15;
    localparam logic [5:0] KIND_PCT    = 6'd16;
    localparam logic [5:0] KIND_DOT    = 6'd17;
    localparam logic [5:0] KIND_COMMA  = 6'd18;
    localparam logic [5:0] KIND_SEMI   = 6'd19;
    localparam logic [5:0] KIND_LPAREN = 6'd20;
    localparam logic [5:0] KIND_RPAREN = 6'd21;
    localparam logic [5:0] KIND_LBRACE = 6'd22;
    localparam logic [5:0] KIND_RBRACE = 6'd23;
    localparam logic [5:0] KIND_ASSIGN = 6'd24;
    localparam logic [5:0] KIND_EQEQ   = 6'd25;
    localparam logic [5:0] KIND_EQEQEQ = 6'd26;
    localparam logic [5:0] KIND_NE     = 6'd27;
    localparam logic [5:0] KIND_NEE    = 6'd28;
    localparam logic [5:0] KIND_LT     = 6'd29;
    localparam logic [5:0] KIND_LE     = 6'd30;
    localparam logic [5:0] KIND_GT     = 6'd31;
    localparam logic [5:0] KIND_GE     = 6'd32;
    localparam logic [5:0] KIND_BANG   = 6'd33;
    localparam logic [5:0] KIND_BAD    = 6'd34;
    localparam logic [5:0] KIND_END    = 6'd35;

    // Characters with a role of their own.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int KW_COUNT = 10;
    localparam int KW_CHARS = 6;

    // Keywords packed first character highest: fn class field let if else while return this null.
    localparam logic [47:0] KW_WORD [KW_COUNT] = '{
        48'h0000_0000_666E, 48'h0063_6C61_7373, 48'h0066_6965_6C64,
        48'h0000_006C_6574, 48'h0000_0000_6966, 48'h0000_656C_7365,
        48'h0077_6869_6C65, 48'h7265_7475_726E, 48'h0000_7468_6973,
        48'h0000_6E75_6C6C
    };
    localparam int KW_LEN [KW_COUNT] = '{2, 5, 5, 3, 2, 4, 5, 6, 4, 4};

    typedef struct packed {
        logic [5:0]  kind;
        logic [62:0] int_value;
        logic        overflow;
        logic [15:0] text_length;
        logic [31:0] token_line;
        logic [7:0]  bad_byte;
    } token_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [5:0] keyword_kind(input logic [47:0] win, input len_t len);
        logic [5:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (len == LEN_BITS'(KW_LEN[k]) && win == KW_WORD[k]) begin
                kind = KIND_KW0 + 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [15:0] sat_length(input len_t len);
        logic [31:0] wide;
        wide = 32'(len);
        return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
    endfunction

    function automatic logic [31:0] line_out(input line_t line);
        logic [63:0] wide;
        wide = 64'(line);
        return wide[31:0];
    endfunction

    function automatic token_t make_token(input logic [5:0] kind, input logic [62:0] value,
                                          input logic ovf, input logic [15:0] len,
                                          input line_t line, input logic [7:0] bad);
        token_t t;
        t.kind        = kind;
        t.int_value   = value;
        t.overflow    = ovf;
        t.text_length = len;
        t.token_line  = line_out(line);
        t.bad_byte    = bad;
        return t;
    endfunction

endpackage

// ===== sv/sbt_lexer.sv =====
// Scanner state and the single-pass next-state logic that turns one input beat into up to
// three tokens. Depends on sbt_pkg.

module sbt_lexer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          in_byte,
    input  logic                in_has,
    input  logic                in_eos,
    output sbt_pkg::token_t     tokens [3],
    output logic [1:0]          token_count
);

    sbt_pkg::mode_t   mode_reg, mode_next;
    logic [47:0]      win_reg, win_next;
    sbt_pkg::len_t    len_reg, len_next;
    logic [62:0]      acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    sbt_pkg::line_t   line_reg, line_next;
    sbt_pkg::line_t   sline_reg, sline_next;

    logic             absorbed;
    logic [67:0]      num_wide;
    logic             a_valid, b_valid, c_valid, d_valid;
    sbt_pkg::token_t  a_tok, b_tok, c_tok, d_tok;
    sbt_pkg::token_t  res [3];
    logic [1:0]       cnt;

    function automatic sbt_pkg::token_t flush_token(
        input sbt_pkg::mode_t mode, input sbt_pkg::len_t len, input logic [62:0] acc,
        input logic ovf, input sbt_pkg::line_t sline, input logic [47:0] win,
        output logic valid);
        sbt_pkg::token_t t;
        valid = 1'b1;
        t = sbt_pkg::make_token(sbt_pkg::KIND_IDENT, '0, 1'b0, 16'd1, sline, 8'd0);
        unique case (mode)
            sbt_pkg::MODE_IDENT: begin
                t = sbt_pkg::make_token(sbt_pkg::keyword_kind(win, len), '0, 1'b0,
                                        sbt_pkg::sat_length(len), sline, 8'd0);
            end
            sbt_pkg::MODE_NUM: begin
                t = sbt_pkg::make_token(sbt_pkg::KIND_INT, acc, ovf,
                                        sbt_pkg::sat_length(len), sline, 8'd0);
            end
            sbt_pkg::MODE_SLASH: t.kind = sbt_pkg::KIND_SLASH;
            sbt_pkg::MODE_EQ1:   t.kind = sbt_pkg::KIND_ASSIGN;
            sbt_pkg::MODE_EQ2: begin
                t.kind        = sbt_pkg::KIND_EQEQ;
                t.text_length = 16'd2;
            end
            sbt_pkg::MODE_BANG1: t.kind = sbt_pkg::KIND_BANG;
            sbt_pkg::MODE_BANG2: begin
                t.kind        = sbt_pkg::KIND_NE;
                t.text_length = 16'd2;
            end
            sbt_pkg::MODE_LT:    t.kind = sbt_pkg::KIND_LT;
            sbt_pkg::MODE_GT:    t.kind = sbt_pkg::KIND_GT;
            default:             valid = 1'b0;
        endcase
        return t;
    endfunction

    always_comb begin
        mode_next  = mode_reg;
        win_next   = win_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        line_next  = line_reg;
        sline_next = sline_reg;
        absorbed   = 1'b0;
        a_valid    = 1'b0;
        b_valid    = 1'b0;
        c_valid    = 1'b0;
        d_valid    = 1'b0;
        a_tok      = '0;
        b_tok      = '0;
        c_tok      = '0;
        d_tok      = '0;
        num_wide   = ({5'd0, acc_reg} << 3) + ({5'd0, acc_reg} << 1) +
                     68'(in_byte - sbt_pkg::CH_ZERO);

        if (in_has) begin
            // A pending token first gets the chance to take the byte.
            unique case (mode_reg) inside
                sbt_pkg::MODE_IDENT: begin
                    if (sbt_pkg::is_alpha(in_byte) || sbt_pkg::is_digit(in_byte)) begin
                        absorbed = 1'b1;
                        if (len_reg < sbt_pkg::LEN_BITS'(sbt_pkg::KW_CHARS)) begin
                            win_next = {win_reg[39:0], in_byte};
                        end
                        if (len_reg != '1) begin
                            len_next = len_reg + 1'b1;
                        end
                    end
                end
                sbt_pkg::MODE_NUM: begin
                    if (sbt_pkg::is_digit(in_byte)) begin
                        absorbed = 1'b1;
                        if (ovf_reg || num_wide > {5'd0, sbt_pkg::INT_MAX}) begin
                            acc_next = sbt_pkg::INT_MAX;
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = num_wide[62:0];
                        end
                        if (len_reg != '1) begin
                            len_next = len_reg + 1'b1;
                        end
                    end
                end
                sbt_pkg::MODE_SLASH: begin
                    if (in_byte == sbt_pkg::CH_SLASH) begin
                        absorbed  = 1'b1;
                        mode_next = sbt_pkg::MODE_COMMENT;
                    end
                end
                sbt_pkg::MODE_COMMENT: begin
                    absorbed = 1'b1;
                    if (in_byte == sbt_pkg::CH_NL) begin
                        line_next = line_reg + 1'b1;
                        mode_next = sbt_pkg::MODE_IDLE;
                    end
                end
                sbt_pkg::MODE_EQ1, sbt_pkg::MODE_BANG1: begin
                    if (in_byte == sbt_pkg::CH_EQ) begin
                        absorbed  = 1'b1;
                        mode_next = (mode_reg == sbt_pkg::MODE_EQ1) ? sbt_pkg::MODE_EQ2
                                                                    : sbt_pkg::MODE_BANG2;
                    end
                end
                sbt_pkg::MODE_EQ2, sbt_pkg::MODE_BANG2, sbt_pkg::MODE_LT,
                sbt_pkg::MODE_GT: begin
                    if (in_byte == sbt_pkg::CH_EQ) begin
                        absorbed  = 1'b1;
                        a_valid   = 1'b1;
                        mode_next = sbt_pkg::MODE_IDLE;
                        a_tok     = sbt_pkg::make_token(sbt_pkg::KIND_GE, '0, 1'b0, 16'd2,
                                                        sline_reg, 8'd0);
                        if (mode_reg == sbt_pkg::MODE_EQ2) begin
                            a_tok.kind        = sbt_pkg::KIND_EQEQEQ;
                            a_tok.text_length = 16'd3;
                        end else if (mode_reg == sbt_pkg::MODE_BANG2) begin
                            a_tok.kind        = sbt_pkg::KIND_NEE;
                            a_tok.text_length = 16'd3;
                        end else if (mode_reg == sbt_pkg::MODE_LT) begin
                            a_tok.kind = sbt_pkg::KIND_LE;
                        end
                    end
                end
                default: begin
                    mode_next = sbt_pkg::MODE_IDLE;
                end
            endcase

            if (!absorbed) begin
                a_tok = flush_token(mode_reg, len_reg, acc_reg, ovf_reg, sline_reg, win_reg,
                                    a_valid);
                mode_next = sbt_pkg::MODE_IDLE;

                // The byte starts afresh from the idle mode.
                if (in_byte == sbt_pkg::CH_SPACE || in_byte == sbt_pkg::CH_TAB ||
                    in_byte == sbt_pkg::CH_CR) begin
                    mode_next = sbt_pkg::MODE_IDLE;
                end else if (in_byte == sbt_pkg::CH_NL) begin
                    line_next = line_reg + 1'b1;
                end else if (sbt_pkg::is_alpha(in_byte)) begin
                    mode_next  = sbt_pkg::MODE_IDENT;
                    sline_next = line_reg;
                    len_next   = sbt_pkg::LEN_BITS'(1);
                    win_next   = {40'd0, in_byte};
                end else if (sbt_pkg::is_digit(in_byte)) begin
                    mode_next  = sbt_pkg::MODE_NUM;
                    sline_next = line_reg;
                    len_next   = sbt_pkg::LEN_BITS'(1);
                    acc_next   = 63'(in_byte - sbt_pkg::CH_ZERO);
                    ovf_next   = 1'b0;
                end else begin
                    b_valid = 1'b1;
                    b_tok   = sbt_pkg::make_token(sbt_pkg::KIND_BAD, '0, 1'b0, 16'd1,
                                                  line_reg, in_byte);
                    case (in_byte) inside
                        sbt_pkg::CH_SLASH, sbt_pkg::CH_EQ, sbt_pkg::CH_BANG, sbt_pkg::CH_LT,
                        sbt_pkg::CH_GT: begin
                            b_valid    = 1'b0;
                            sline_next = line_reg;
                            len_next   = sbt_pkg::LEN_BITS'(1);
                            if (in_byte == sbt_pkg::CH_SLASH) begin
                                mode_next = sbt_pkg::MODE_SLASH;
                            end else if (in_byte == sbt_pkg::CH_EQ) begin
                                mode_next = sbt_pkg::MODE_EQ1;
                            end else if (in_byte == sbt_pkg::CH_BANG) begin
                                mode_next = sbt_pkg::MODE_BANG1;
                            end else if (in_byte == sbt_pkg::CH_LT) begin
                                mode_next = sbt_pkg::MODE_LT;
                            end else begin
                                mode_next = sbt_pkg::MODE_GT;
                            end
                        end
                        sbt_pkg::CH_PLUS:   b_tok.kind = sbt_pkg::KIND_PLUS;
                        sbt_pkg::CH_MINUS:  b_tok.kind = sbt_pkg::KIND_MINUS;
                        sbt_pkg::CH_STAR:   b_tok.kind = sbt_pkg::KIND_STAR;
                        sbt_pkg::CH_PCT:    b_tok.kind = sbt_pkg::KIND_PCT;
                        sbt_pkg::CH_DOT:    b_tok.kind = sbt_pkg::KIND_DOT;
                        sbt_pkg::CH_COMMA:  b_tok.kind = sbt_pkg::KIND_COMMA;
                        sbt_pkg::CH_SEMI:   b_tok.kind = sbt_pkg::KIND_SEMI;
                        sbt_pkg::CH_LPAR:   b_tok.kind = sbt_pkg::KIND_LPAREN;
                        sbt_pkg::CH_RPAR:   b_tok.kind = sbt_pkg::KIND_RPAREN;
                        sbt_pkg::CH_LBRACE: b_tok.kind = sbt_pkg::KIND_LBRACE;
                        sbt_pkg::CH_RBRACE: b_tok.kind = sbt_pkg::KIND_RBRACE;
                        default:            b_tok.kind = sbt_pkg::KIND_BAD;
                    endcase
                    if (b_tok.kind != sbt_pkg::KIND_BAD) begin
                        b_tok.bad_byte = 8'd0;
                    end
                end
            end
        end

        if (in_eos) begin
            c_tok = flush_token(mode_next, len_next, acc_next, ovf_next, sline_next, win_next,
                                c_valid);
            d_valid = 1'b1;
            d_tok   = sbt_pkg::make_token(sbt_pkg::KIND_END, '0, 1'b0, 16'd0, line_next, 8'd0);
            mode_next  = sbt_pkg::MODE_IDLE;
            win_next   = '0;
            len_next   = '0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            line_next  = sbt_pkg::LINE_BITS'(1);
            sline_next = sbt_pkg::LINE_BITS'(1);
        end

        // Pack the candidates in order, at most three.
        res = '{default: '0};
        cnt = 2'd0;
        if (a_valid && cnt < 2'd3) begin
            res[cnt] = a_tok;
            cnt      = cnt + 2'd1;
        end
        if (b_valid && cnt < 2'd3) begin
            res[cnt] = b_tok;
            cnt      = cnt + 2'd1;
        end
        if (c_valid && cnt < 2'd3) begin
            res[cnt] = c_tok;
            cnt      = cnt + 2'd1;
        end
        if (d_valid && cnt < 2'd3) begin
            res[cnt] = d_tok;
            cnt      = cnt + 2'd1;
        end
    end

    assign tokens      = res;
    assign token_count = cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sbt_pkg::MODE_IDLE;
            win_reg   <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            line_reg  <= sbt_pkg::LINE_BITS'(1);
            sline_reg <= sbt_pkg::LINE_BITS'(1);
        end else if (step) begin
            mode_reg  <= mode_next;
            win_reg   <= win_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            line_reg  <= line_next;
            sline_reg <= sline_next;
        end
    end

endmodule

// ===== sv/sbt_result_queue.sv =====
// Result register holding the up to three tokens of one input beat and handing them out one
// beat at a time. Depends on sbt_pkg.

module sbt_result_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  sbt_pkg::token_t  load_tokens [3],
    input  logic [1:0]       load_count,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             out_last,
    output sbt_pkg::token_t  out_token,
    output logic             can_load
);

    sbt_pkg::token_t  slot_reg [3];
    logic [1:0]       rem_reg;
    logic             pop;

    assign out_valid = rem_reg != 2'd0;
    assign out_last  = rem_reg == 2'd1;
    assign out_token = slot_reg[0];
    assign pop       = out_valid && out_ready;
    assign can_load  = (rem_reg == 2'd0) || (rem_reg == 2'd1 && out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
        end else if (load) begin
            rem_reg <= load_count;
        end else if (pop) begin
            rem_reg <= rem_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= load_tokens;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

// ===== sv/source_byte_tokenizer_unit.sv =====
// Top level of the source byte tokenizer: input register, scanner and result register.
// Depends on sbt_pkg, sbt_lexer and sbt_result_queue.
//
//   Channel  Dir  tdata                                   tuser          tlast
//   s_       in   source_byte                             has_byte       end_of_source
//   m_       out  int_value, value_overflow, text_length, token_kind     last_result
//                 token_line, bad_byte
//
// A beat is held in the input register and is scanned as it moves into the result register,
// where its first token is presented.
// The result port sends one token per cycle while m_tready is high. A beat with several tokens
// holds the scanner until its last is taken; zero or one token lets a new beat in every cycle.
// Reset is synchronous and puts the scanner on line 1 with no token pending.
// A stall on the result side backs up into the input register and then into s_tready.

module source_byte_tokenizer_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] source_byte
    input  logic          s_tuser,   // has_byte
    input  logic          s_tlast,   // end_of_source
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [119:0]  m_tdata,   // [62:0] int_value, [63] value_overflow,
                                     // [79:64] text_length, [111:80] token_line,
                                     // [119:112] bad_byte
    output logic [5:0]    m_tuser,   // token_kind
    output logic          m_tlast    // last_result
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_has_reg;
    logic             in_eos_reg;
    logic             can_load;
    logic             advance;
    sbt_pkg::token_t  tokens [3];
    logic [1:0]       token_count;
    sbt_pkg::token_t  head;

    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_eos_reg  <= s_tlast;
        end
    end

    sbt_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .in_byte     (in_byte_reg),
        .in_has      (in_has_reg),
        .in_eos      (in_eos_reg),
        .tokens      (tokens),
        .token_count (token_count)
    );

    sbt_result_queue u_result_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .load_tokens (tokens),
        .load_count  (token_count),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_last    (m_tlast),
        .out_token   (head),
        .can_load    (can_load)
    );

    assign m_tuser = head.kind;
    assign m_tdata = {head.bad_byte, head.token_line, head.text_length, head.overflow,
                      head.int_value};

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_eos_reg |=> m_tvalid)
        else $error("End of source beat produced no token.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_has_reg && !in_eos_reg |=> !m_tvalid)
        else $error("Empty beat produced a token.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("Token run ended without a last beat.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= sbt_pkg::KIND_END)
        else $error("Token kind out of range.");

endmodule
